// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the keypad decoder RTL.
// Depends on nothing; files that check their own logic include it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on the rising clock edge, ignored while reset is held
`define BKD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that a condition never holds on the rising clock edge
`define BKD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`else

`define BKD_ASSERT(lbl, clk, rst_n, prop, msg)
`define BKD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ===== rtl/bkd_pkg.sv =====
// Types and codes for the braille keypad packet decoder.
// No dependencies; used by the interfaces and every module.
package bkd_pkg;

    // Input operation codes
    typedef enum logic [1:0] {
        OP_RX_BYTE    = 2'd0,
        OP_POP        = 2'd1,
        OP_FRAME_SENT = 2'd2,
        OP_TIMEOUT    = 2'd3
    } t_opcode;

    // Result event codes
    typedef enum logic [2:0] {
        EV_NOTHING  = 3'd0,
        EV_ACK      = 3'd1,
        EV_QUEUED   = 3'd2,
        EV_OVERFLOW = 3'd3,
        EV_POPPED   = 3'd4,
        EV_EMPTY    = 3'd5
    } t_event;

    // Key kinds
    typedef enum logic [2:0] {
        KIND_NONE   = 3'd0,
        KIND_DOT    = 3'd1,
        KIND_CHORD  = 3'd2,
        KIND_CMD    = 3'd3,
        KIND_CURSOR = 3'd4
    } t_kind;

    localparam int CODE_W = 7;
    localparam int DOTS_W = 8;

    // Command codes carried in the key code field
    localparam logic [CODE_W-1:0] CMD_BACK    = 7'd0;
    localparam logic [CODE_W-1:0] CMD_ESCAPE  = 7'd1;
    localparam logic [CODE_W-1:0] CMD_RETURN  = 7'd2;
    localparam logic [CODE_W-1:0] CMD_FORWARD = 7'd3;

    // One queued key
    typedef struct packed {
        t_kind               kind;
        logic [CODE_W-1:0]   code;
        logic [DOTS_W-1:0]   dots;
    } t_key;

    // What the parser asks of the rest of the block for one transfer
    typedef struct packed {
        logic have_key;
        logic ack_seen;
        logic pop_req;
        t_key key;
    } t_parse_req;

endpackage

// ===== rtl/bkd_if.sv =====
// Valid/ready channel interfaces for the keypad decoder.
// Depends on bkd_pkg for the payload types.
interface bkd_in_if;
    logic              valid;
    logic              ready;
    bkd_pkg::t_opcode  opcode;
    logic [7:0]        rx_byte;

    modport source (output valid, output opcode, output rx_byte, input ready);
    modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface bkd_out_if #(
    parameter int QUEUE_DEPTH = 16
);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic                         valid;
    logic                         ready;
    bkd_pkg::t_event              event_res;
    bkd_pkg::t_kind               key_kind;
    logic [bkd_pkg::CODE_W-1:0]   key_code;
    logic [bkd_pkg::DOTS_W-1:0]   dot_pattern;
    logic [CNT_W-1:0]             queue_count;

    modport source (output valid, output event_res, output key_kind, output key_code,
                    output dot_pattern, output queue_count, input ready);
    modport sink   (input valid, input event_res, input key_kind, input key_code,
                    input dot_pattern, input queue_count, output ready);
endinterface

// ===== rtl/bkd_parser.sv =====
// Byte stream parser and key decoder for the keypad decoder.
// Depends on bkd_pkg; holds the packet phase, held byte and acknowledge flag.
module bkd_parser (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  bkd_pkg::t_opcode             i_opcode,
    input  logic [7:0]                   i_rx_byte,
    input  logic [bkd_pkg::CODE_W-1:0]   i_display_width,
    output bkd_pkg::t_parse_req          o_req
);
    import bkd_pkg::*;

    // Packet phase, one-hot
    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_LEAD = 3'b010,
        PH_DATA = 3'b100
    } t_phase;

    localparam logic [7:0] BYTE_ACK      = 8'h05;
    localparam logic [7:0] BYTE_PREFIX   = 8'h00;
    localparam logic [7:0] BYTE_ADVANCE  = 8'h80;
    localparam logic [7:0] BYTE_BACK     = 8'h83;
    localparam logic [7:0] EXT_BACK      = 8'h88;
    localparam logic [7:0] EXT_ESCAPE    = 8'h84;
    localparam logic [7:0] EXT_RETURN    = 8'h82;
    localparam logic [7:0] EXT_FORWARD   = 8'h81;
    localparam logic [CODE_W-1:0] BASIC_MODEL_WIDTH = 7'd18;

    t_phase     r_phase, n_phase;
    logic [7:0] r_held, n_held;
    logic       r_ack, n_ack;

    function automatic t_key make_key(t_kind kind, logic [CODE_W-1:0] code,
                                      logic [DOTS_W-1:0] dots);
        t_key k;
        k.kind = kind;
        k.code = code;
        k.dots = dots;
        return k;
    endfunction

    // Single-byte key
    function automatic t_key decode_basic(logic [7:0] b);
        t_key k;
        if (b[7]) begin
            if (b == BYTE_ADVANCE) begin
                k = make_key(KIND_CMD, CMD_FORWARD, '0);
            end else if (b == BYTE_BACK) begin
                k = make_key(KIND_CMD, CMD_BACK, '0);
            end else begin
                k = make_key(KIND_NONE, '0, '0);
            end
        end else begin
            k = make_key(b[6] ? KIND_CHORD : KIND_DOT, '0, {2'b00, b[5:0]});
        end
        return k;
    endfunction

    // Two data bytes of an extended packet
    function automatic t_key decode_ext(logic [7:0] b0, logic [7:0] b1,
                                        logic [CODE_W-1:0] width);
        t_key k;
        if (b0 != 8'h00) begin
            k = make_key(b1[6] ? KIND_CHORD : KIND_DOT, '0, b0);
        end else if (b1[7]) begin
            case (b1)
                EXT_BACK:    k = make_key(KIND_CMD, CMD_BACK, '0);
                EXT_ESCAPE:  k = make_key(KIND_CMD, CMD_ESCAPE, '0);
                EXT_RETURN:  k = make_key(KIND_CMD, CMD_RETURN, '0);
                EXT_FORWARD: k = make_key(KIND_CMD, CMD_FORWARD, '0);
                default:     k = make_key(KIND_NONE, '0, '0);
            endcase
        end else if (b1[6:0] != '0 && b1[6:0] <= width) begin
            k = make_key(KIND_CURSOR, b1[6:0] - 7'd1, '0);
        end else begin
            k = make_key(KIND_NONE, '0, '0);
        end
        return k;
    endfunction

    // Decode the offered item against the current phase
    always_comb begin
        n_phase = r_phase;
        n_held  = r_held;
        n_ack   = r_ack;
        o_req   = '0;
        case (i_opcode)
            OP_RX_BYTE: begin
                case (r_phase)
                    PH_LEAD: begin
                        n_held  = i_rx_byte;
                        n_phase = PH_DATA;
                    end
                    PH_DATA: begin
                        o_req.have_key = 1'b1;
                        o_req.key      = decode_ext(r_held, i_rx_byte, i_display_width);
                        n_phase        = PH_IDLE;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                        if (r_ack && i_rx_byte == BYTE_ACK) begin
                            n_ack          = 1'b0;
                            o_req.ack_seen = 1'b1;
                        end else if (i_rx_byte == BYTE_PREFIX) begin
                            n_phase = PH_LEAD;
                        end else if (i_rx_byte == BYTE_ADVANCE &&
                                     i_display_width != BASIC_MODEL_WIDTH) begin
                            o_req.have_key = 1'b1;
                            o_req.key      = make_key(KIND_NONE, '0, '0);
                        end else begin
                            o_req.have_key = 1'b1;
                            o_req.key      = decode_basic(i_rx_byte);
                        end
                    end
                endcase
            end
            OP_POP:        o_req.pop_req = 1'b1;
            OP_FRAME_SENT: n_ack = 1'b1;
            OP_TIMEOUT:    n_phase = PH_IDLE;
            default: ;
        endcase
    end

    // Advance parser state on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_held  <= 8'h00;
            r_ack   <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_held  <= n_held;
            r_ack   <= n_ack;
        end
    end

endmodule

// ===== rtl/bkd_fifo.sv =====
// Key queue for the keypad decoder: one write port, one registered read port.
// Depends on bkd_pkg for the key type and on assert_macros.svh.
`include "assert_macros.svh"

module bkd_fifo #(
    parameter int QUEUE_DEPTH = 16,
    parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic                 i_pop,
    input  bkd_pkg::t_key        i_wr_key,
    output logic                 o_full,
    output logic                 o_empty,
    output logic [CNT_W-1:0]     o_count_next,
    output bkd_pkg::t_key        o_rd_key
);
    import bkd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    t_key             mem [QUEUE_DEPTH];
    t_key             r_rd_key;
    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full       = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty      = (r_count == '0);
    assign o_count_next = n_count;
    assign o_rd_key     = r_rd_key;

    // Advance pointers with wrap at the queue depth
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_push) begin
            n_tail  = (r_tail == LAST_PTR) ? '0 : r_tail + PTR_W'(1);
            n_count = r_count + CNT_W'(1);
        end
        if (i_pop) begin
            n_head  = (r_head == LAST_PTR) ? '0 : r_head + PTR_W'(1);
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // Write at the tail, read the head into the data register
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            mem[r_tail] <= i_wr_key;
        end
        if (i_pop) begin
            r_rd_key <= mem[r_head];
        end
    end

    `BKD_ASSERT_NEVER(a_count_range, i_clk, i_rst_n, (r_count > CNT_W'(QUEUE_DEPTH)), "queue count beyond depth")
    `BKD_ASSERT(a_pop_drops_count, i_clk, i_rst_n, (i_pop |=> (r_count == $past(r_count) - CNT_W'(1))), "pop did not reduce count")
    `BKD_ASSERT(a_empty_ptrs, i_clk, i_rst_n, ((r_count == '0) |-> (r_head == r_tail)), "empty queue with split pointers")

endmodule

// ===== rtl/braille_keypad_packet_decoder.sv =====
// Braille keypad packet decoder, top level.
// Each result is registered in the result stage and then in the output register.
// Throughput: one item per cycle unless stalled; the parser and key queue each take one step.
// A one-entry result stage ahead of the output register takes one more item during a stall.
// Reset: synchronous, active low; queue empties at once, no clearing pass.
`include "assert_macros.svh"

module braille_keypad_packet_decoder #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [bkd_pkg::CODE_W-1:0]  i_cfg_wdata,
    bkd_in_if.sink                      i_in,
    bkd_out_if.source                   o_out
);
    import bkd_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CODE_W-1:0] WIDTH_RESET = 7'd40;

    logic [CODE_W-1:0] r_display_width;

    t_parse_req        req;
    logic              in_accept;
    logic              push_ok, pop_ok;
    logic              q_full, q_empty;
    logic [CNT_W-1:0]  q_count_next;
    t_key              q_rd_key;

    t_event            n_ev;
    t_key              n_key;
    logic              n_sel_mem;

    // Result stage
    logic              r_s1_valid;
    t_event            r_s1_ev;
    t_key              r_s1_key;
    logic              r_s1_sel_mem;
    logic [CNT_W-1:0]  r_s1_count;
    t_key              s1_key;
    logic              s1_move;

    // Output register
    logic              r_o_valid;
    t_event            r_o_ev;
    t_key              r_o_key;
    logic [CNT_W-1:0]  r_o_count;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_width <= WIDTH_RESET;
        end else if (i_cfg_we) begin
            r_display_width <= i_cfg_wdata;
        end
    end

    // Handshake: result stage moves on when the output register is free or draining
    assign s1_move     = r_s1_valid && (!r_o_valid || o_out.ready);
    assign i_in.ready  = !r_s1_valid || s1_move;
    assign in_accept   = i_in.valid && i_in.ready;

    bkd_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (in_accept),
        .i_opcode        (i_in.opcode),
        .i_rx_byte       (i_in.rx_byte),
        .i_display_width (r_display_width),
        .o_req           (req)
    );

    assign push_ok = in_accept && req.have_key && !q_full;
    assign pop_ok  = in_accept && req.pop_req && !q_empty;

    bkd_fifo #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CNT_W       (CNT_W)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push_ok),
        .i_pop        (pop_ok),
        .i_wr_key     (req.key),
        .o_full       (q_full),
        .o_empty      (q_empty),
        .o_count_next (q_count_next),
        .o_rd_key     (q_rd_key)
    );

    // Form the event for this transfer
    always_comb begin
        n_ev      = EV_NOTHING;
        n_key     = '0;
        n_sel_mem = 1'b0;
        if (req.ack_seen) begin
            n_ev = EV_ACK;
        end
        if (req.have_key) begin
            n_ev  = q_full ? EV_OVERFLOW : EV_QUEUED;
            n_key = req.key;
        end
        if (req.pop_req) begin
            n_ev      = q_empty ? EV_EMPTY : EV_POPPED;
            n_sel_mem = !q_empty;
        end
    end

    // Result stage: hold until the output register takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_ev      <= n_ev;
            r_s1_key     <= n_key;
            r_s1_sel_mem <= n_sel_mem;
            r_s1_count   <= q_count_next;
        end
    end

    // Popped keys come from the queue read register
    assign s1_key = r_s1_sel_mem ? q_rd_key : r_s1_key;

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_move) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_o_ev    <= r_s1_ev;
            r_o_key   <= s1_key;
            r_o_count <= r_s1_count;
        end
    end

    assign o_out.valid       = r_o_valid;
    assign o_out.event_res   = r_o_ev;
    assign o_out.key_kind    = r_o_key.kind;
    assign o_out.key_code    = r_o_key.code;
    assign o_out.dot_pattern = r_o_key.dots;
    assign o_out.queue_count = r_o_count;

    `BKD_ASSERT(a_accept_lands, i_clk, i_rst_n, (in_accept |=> r_s1_valid), "accepted item lost before result stage")
    `BKD_ASSERT(a_stall_holds, i_clk, i_rst_n, ((r_s1_valid && !s1_move) |=> (r_s1_valid && $stable(r_s1_ev))), "stalled result stage changed")
    `BKD_ASSERT(a_out_holds, i_clk, i_rst_n, ((r_o_valid && !o_out.ready) |=> (r_o_valid && $stable(r_o_ev))), "stalled output changed")

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the braille keypad packet decoder.
// Depends on bkd_pkg and the bkd_in_if / bkd_out_if interfaces from the RTL;
// predicts every result in step with each input transfer and checks in order.
module tb;
    import bkd_pkg::*;

    localparam int KEY_DEPTH = 16;
    localparam int COUNT_W   = $clog2(KEY_DEPTH + 1);

    // Byte values with a fixed meaning on the terminal link
    localparam logic [7:0] ACK_BYTE      = 8'h05;
    localparam logic [7:0] PACKET_PREFIX = 8'h00;
    localparam logic [7:0] BASIC_FORWARD = 8'h80;
    localparam logic [7:0] BASIC_BACK    = 8'h83;
    localparam logic [7:0] EXT_BACK      = 8'h88;
    localparam logic [7:0] EXT_ESCAPE    = 8'h84;
    localparam logic [7:0] EXT_RETURN    = 8'h82;
    localparam logic [7:0] EXT_FORWARD   = 8'h81;
    localparam logic [CODE_W-1:0] BASIC_MODEL_WIDTH = 7'd18;
    localparam logic [CODE_W-1:0] RESET_WIDTH       = 7'd40;

    // Parser phases
    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_PREFIX = 2'd1;
    localparam logic [1:0] PH_FIRST  = 2'd2;

    typedef struct packed {
        t_event              ev;
        t_kind               kind;
        logic [CODE_W-1:0]   code;
        logic [DOTS_W-1:0]   dots;
        logic [COUNT_W-1:0]  count;
    } t_keypad_result;

    typedef struct packed {
        t_opcode         op;
        logic [7:0]      rx;
        logic            typed;
        t_keypad_result  want;
    } t_stim_row;

    localparam t_keypad_result NO_WANT = '0;

    // Directed opening: typed results where they are obvious, else predicted
    localparam t_stim_row STIM_TABLE [24] = '{
        '{OP_POP,        8'h00, 1'b1, '{EV_EMPTY,   KIND_NONE,   7'd0,     8'h00, 5'd0}},
        '{OP_RX_BYTE,    8'h05, 1'b1, '{EV_QUEUED,  KIND_DOT,    7'd0,     8'h05, 5'd1}},
        '{OP_FRAME_SENT, 8'hFF, 1'b1, '{EV_NOTHING, KIND_NONE,   7'd0,     8'h00, 5'd1}},
        '{OP_RX_BYTE,    8'h00, 1'b1, '{EV_NOTHING, KIND_NONE,   7'd0,     8'h00, 5'd1}},
        '{OP_RX_BYTE,    8'h05, 1'b0, NO_WANT},
        '{OP_RX_BYTE,    8'h05, 1'b0, NO_WANT},
        '{OP_RX_BYTE,    8'h05, 1'b1, '{EV_ACK,     KIND_NONE,   7'd0,     8'h00, 5'd2}},
        '{OP_RX_BYTE,    8'h80, 1'b1, '{EV_QUEUED,  KIND_NONE,   7'd0,     8'h00, 5'd3}},
        '{OP_RX_BYTE,    8'h83, 1'b1, '{EV_QUEUED,  KIND_CMD,    CMD_BACK, 8'h00, 5'd4}},
        '{OP_RX_BYTE,    8'hFF, 1'b1, '{EV_QUEUED,  KIND_NONE,   7'd0,     8'h00, 5'd5}},
        '{OP_RX_BYTE,    8'h7F, 1'b1, '{EV_QUEUED,  KIND_CHORD,  7'd0,     8'h3F, 5'd6}},
        '{OP_RX_BYTE,    8'h00, 1'b0, NO_WANT},
        '{OP_RX_BYTE,    8'h00, 1'b0, NO_WANT},
        '{OP_RX_BYTE,    8'h88, 1'b0, NO_WANT},
        '{OP_RX_BYTE,    8'h00, 1'b0, NO_WANT},
        '{OP_RX_BYTE,    8'h00, 1'b0, NO_WANT},
        '{OP_RX_BYTE,    8'h28, 1'b1, '{EV_QUEUED,  KIND_CURSOR, 7'd39,    8'h00, 5'd8}},
        '{OP_RX_BYTE,    8'h00, 1'b0, NO_WANT},
        '{OP_RX_BYTE,    8'h00, 1'b0, NO_WANT},
        '{OP_RX_BYTE,    8'h29, 1'b0, NO_WANT},
        '{OP_RX_BYTE,    8'h00, 1'b0, NO_WANT},
        '{OP_TIMEOUT,    8'hA5, 1'b1, '{EV_NOTHING, KIND_NONE,   7'd0,     8'h00, 5'd9}},
        '{OP_RX_BYTE,    8'h41, 1'b0, NO_WANT},
        '{OP_POP,        8'h5A, 1'b1, '{EV_POPPED,  KIND_DOT,    7'd0,     8'h05, 5'd9}}
    };

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CODE_W-1:0]   i_cfg_wdata;

    bkd_in_if                                in_ch ();
    bkd_out_if #(.QUEUE_DEPTH(KEY_DEPTH))    out_ch ();

    braille_keypad_packet_decoder #(.QUEUE_DEPTH(KEY_DEPTH)) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // Predictor state
    logic [CODE_W-1:0]  cell_count = RESET_WIDTH;
    logic [1:0]         rx_phase   = PH_IDLE;
    logic [7:0]         first_byte = 8'h00;
    logic               ack_pending = 1'b0;
    t_key               key_fifo [$];

    t_keypad_result     expected_q [$];
    bit                 quiet_sender = 1'b0;
    int unsigned        items_sent = 0;
    int unsigned        fail_count = 0;
    int unsigned        seen_queued = 0, seen_dropped = 0, seen_popped = 0;
    int unsigned        seen_empty = 0, seen_ack = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin : watchdog
        #2000000;
        $display("simulation failed");
        $finish;
    end

    // Decode a lone byte
    function automatic t_key basic_key(logic [7:0] b);
        t_key k;
        k = '0;
        if (b[7]) begin
            if (b == BASIC_FORWARD) begin
                k.kind = KIND_CMD;
                k.code = CMD_FORWARD;
            end else if (b == BASIC_BACK) begin
                k.kind = KIND_CMD;
                k.code = CMD_BACK;
            end
        end else begin
            k.kind = b[6] ? KIND_CHORD : KIND_DOT;
            k.dots = {2'b00, b[5:0]};
        end
        return k;
    endfunction

    // Decode the two bytes after a packet prefix
    function automatic t_key packet_key(logic [7:0] b0, logic [7:0] b1);
        t_key k;
        k = '0;
        if (b0 != 8'h00) begin
            k.kind = b1[6] ? KIND_CHORD : KIND_DOT;
            k.dots = b0;
        end else if (b1[7]) begin
            k.kind = KIND_CMD;
            case (b1)
                EXT_BACK:    k.code = CMD_BACK;
                EXT_ESCAPE:  k.code = CMD_ESCAPE;
                EXT_RETURN:  k.code = CMD_RETURN;
                EXT_FORWARD: k.code = CMD_FORWARD;
                default:     k.kind = KIND_NONE;
            endcase
        end else if (b1 != 8'h00 && b1[6:0] <= cell_count) begin
            k.kind = KIND_CURSOR;
            k.code = b1[6:0] - 7'd1;
        end
        return k;
    endfunction

    // Advance the predictor by one accepted item and return its result
    function automatic t_keypad_result keypad_step(t_opcode op, logic [7:0] b);
        t_keypad_result r;
        t_key           k;
        bit             got;
        r   = '0;
        k   = '0;
        got = 1'b0;
        case (op)
            OP_RX_BYTE: begin
                if (rx_phase == PH_PREFIX) begin
                    first_byte = b;
                    rx_phase   = PH_FIRST;
                end else if (rx_phase == PH_FIRST) begin
                    k        = packet_key(first_byte, b);
                    got      = 1'b1;
                    rx_phase = PH_IDLE;
                end else begin
                    rx_phase = PH_IDLE;
                    if (ack_pending && b == ACK_BYTE) begin
                        ack_pending = 1'b0;
                        r.ev        = EV_ACK;
                    end else if (b == PACKET_PREFIX) begin
                        rx_phase = PH_PREFIX;
                    end else if (b == BASIC_FORWARD && cell_count != BASIC_MODEL_WIDTH) begin
                        got = 1'b1;
                    end else begin
                        k   = basic_key(b);
                        got = 1'b1;
                    end
                end
                if (got) begin
                    if (key_fifo.size() >= KEY_DEPTH) begin
                        r.ev = EV_OVERFLOW;
                    end else begin
                        key_fifo.push_back(k);
                        r.ev = EV_QUEUED;
                    end
                end
            end
            OP_POP: begin
                if (key_fifo.size() == 0) begin
                    r.ev = EV_EMPTY;
                end else begin
                    k    = key_fifo.pop_front();
                    got  = 1'b1;
                    r.ev = EV_POPPED;
                end
            end
            OP_FRAME_SENT: ack_pending = 1'b1;
            default:       rx_phase = PH_IDLE;
        endcase
        if (got) begin
            r.kind = k.kind;
            r.code = k.code;
            r.dots = k.dots;
        end
        r.count = COUNT_W'(key_fifo.size());
        return r;
    endfunction

    // Mostly no gap, sometimes a short one, now and then a long one
    function automatic int unsigned next_gap();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (quiet_sender || pick < 65)
            return 0;
        if (pick < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one item, hold it until the transfer, then record its expectation
    task automatic send_item(t_opcode op, logic [7:0] b, bit typed, t_keypad_result want);
        t_keypad_result predicted;
        int unsigned    gap;
        in_ch.valid   <= 1'b1;
        in_ch.opcode  <= op;
        in_ch.rx_byte <= b;
        do @(posedge i_clk); while (!in_ch.ready);
        predicted = keypad_step(op, b);
        expected_q.push_back(typed ? want : predicted);
        items_sent++;
        gap = next_gap();
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic feed(t_opcode op, logic [7:0] b);
        send_item(op, b, 1'b0, NO_WANT);
    endtask

    // Drop valid and hold until every result is back, then let the pipe settle
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_cell_count(logic [CODE_W-1:0] w);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= w;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cell_count   = w;
    endtask

    // Random key traffic: mostly well-formed packets and keys, some noise
    task automatic key_traffic(int unsigned n, int unsigned pop_weight);
        int unsigned target, pick;
        logic [7:0]  b0, b1;
        target = items_sent + n;
        while (items_sent < target) begin
            if ($urandom_range(0, 39) == 0)
                quiet_sender = !quiet_sender;
            if ($urandom_range(0, 199) == 0)
                wait_drained();
            pick = $urandom_range(0, 99);
            if (pick < pop_weight) begin
                feed(OP_POP, 8'($urandom));
            end else if (pick < pop_weight + 30) begin
                // extended packet
                b0 = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom);
                case ($urandom_range(0, 3))
                    0: begin
                        case ($urandom_range(0, 3))
                            0: b1 = EXT_BACK;
                            1: b1 = EXT_ESCAPE;
                            2: b1 = EXT_RETURN;
                            default: b1 = EXT_FORWARD;
                        endcase
                    end
                    1: b1 = 8'($urandom_range(0, cell_count + 2));
                    default: b1 = 8'($urandom);
                endcase
                feed(OP_RX_BYTE, PACKET_PREFIX);
                if ($urandom_range(0, 9) == 0)
                    feed(OP_POP, 8'($urandom));
                feed(OP_RX_BYTE, b0);
                feed(OP_RX_BYTE, b1);
            end else if (pick < pop_weight + 55) begin
                // lone key byte, leaning on the special ones
                case ($urandom_range(0, 9))
                    0: b0 = BASIC_FORWARD;
                    1: b0 = BASIC_BACK;
                    2: b0 = ACK_BYTE;
                    default: b0 = 8'($urandom);
                endcase
                feed(OP_RX_BYTE, b0);
            end else if (pick < pop_weight + 63) begin
                feed(OP_FRAME_SENT, 8'($urandom));
                if ($urandom_range(0, 9) < 7)
                    feed(OP_RX_BYTE, ACK_BYTE);
            end else if (pick < pop_weight + 68) begin
                // packet cut short by a timeout
                feed(OP_RX_BYTE, PACKET_PREFIX);
                if ($urandom_range(0, 1) == 0)
                    feed(OP_RX_BYTE, 8'($urandom));
                feed(OP_TIMEOUT, 8'($urandom));
            end else begin
                feed(($urandom_range(0, 1) == 0) ? OP_TIMEOUT : OP_FRAME_SENT, 8'($urandom));
            end
        end
    endtask

    // Receiver pacing: bursts of ready, short and long stalls, calm stretches
    initial begin : sink_pacing
        int unsigned pick, hold;
        logic        level;
        forever begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                level = 1'b1;
                hold  = $urandom_range(60, 200);
            end else if (pick < 70) begin
                level = 1'b1;
                hold  = $urandom_range(1, 6);
            end else if (pick < 93) begin
                level = 1'b0;
                hold  = $urandom_range(1, 3);
            end else begin
                level = 1'b0;
                hold  = $urandom_range(10, 40);
            end
            out_ch.ready <= level;
            repeat (hold) @(posedge i_clk);
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_keypad_result seen, want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            seen = '{out_ch.event_res, out_ch.key_kind, out_ch.key_code,
                     out_ch.dot_pattern, out_ch.queue_count};
            if (expected_q.size() == 0) begin
                $error("result with nothing expected: event_res %0d", seen.ev);
                fail_count++;
            end else begin
                want = expected_q.pop_front();
                if (seen.ev !== want.ev) begin
                    $error("event_res: expected %0d, got %0d", want.ev, seen.ev);
                    fail_count++;
                end
                if (seen.kind !== want.kind) begin
                    $error("key_kind: expected %0d, got %0d", want.kind, seen.kind);
                    fail_count++;
                end
                if (seen.code !== want.code) begin
                    $error("key_code: expected %0d, got %0d", want.code, seen.code);
                    fail_count++;
                end
                if (seen.dots !== want.dots) begin
                    $error("dot_pattern: expected 0x%02h, got 0x%02h", want.dots, seen.dots);
                    fail_count++;
                end
                if (seen.count !== want.count) begin
                    $error("queue_count: expected %0d, got %0d", want.count, seen.count);
                    fail_count++;
                end
                case (want.ev)
                    EV_QUEUED:   seen_queued++;
                    EV_OVERFLOW: seen_dropped++;
                    EV_POPPED:   seen_popped++;
                    EV_EMPTY:    seen_empty++;
                    EV_ACK:      seen_ack++;
                    default: ;
                endcase
            end
        end
    end

    initial begin : stimulus
        logic [CODE_W-1:0] widths [6];
        int unsigned       pop_weights [6];
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        in_ch.valid   <= 1'b0;
        in_ch.opcode  <= OP_RX_BYTE;
        in_ch.rx_byte <= 8'h00;
        widths      = '{BASIC_MODEL_WIDTH, 7'd1, 7'd80, 7'($urandom_range(2, 79)),
                        7'($urandom_range(1, 80)), RESET_WIDTH};
        pop_weights = '{10, 60, 30, 10, 55, 30};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening at the reset width
        foreach (STIM_TABLE[i])
            send_item(STIM_TABLE[i].op, STIM_TABLE[i].rx, STIM_TABLE[i].typed,
                      STIM_TABLE[i].want);

        // Random phases, each at its own display width
        for (int p = 0; p < 6; p++) begin
            set_cell_count(widths[p]);
            key_traffic(300, pop_weights[p]);
        end

        wait_drained();
        if (expected_q.size() != 0) begin
            $error("%0d results never arrived", expected_q.size());
            fail_count++;
        end
        $display("run: %0d input transfers over six display widths incl. 1, 18 and 80",
                 items_sent);
        $display("results: %0d queued, %0d dropped when full, %0d popped, %0d empty pops, %0d acks",
                 seen_queued, seen_dropped, seen_popped, seen_empty, seen_ack);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
